[design/tlbpt_pkg.sv]
// tlbpt_pkg: shared constants and control types of the page table translator
// used by the channel interfaces, the tlb, the lru list and the top level
package tlbpt_pkg;

  localparam int PAGE_COUNT_DEF  = 256;
  localparam int FRAME_COUNT_DEF = 128;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_BYTES_DEF  = 256;

  localparam int VA_W    = 16;
  localparam int PA_W    = 15;
  localparam int EVP_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLB_POLICY   = 2'd1;

  typedef struct packed {
    logic inval;
    logic insert;
    logic touch;
    logic lru_policy;
  } tlb_ctl_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic step_a;
    logic step_b;
  } lru_ctl_t;

endpackage

[design/tlbpt_if.sv]
// tlbpt channel interfaces: input, result and configuration write channels
// depends on tlbpt_pkg for field widths
interface tlbpt_in_if import tlbpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VA_W-1:0] virtual_address;
  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_out_if import tlbpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PA_W-1:0]  physical_address;
  logic             tlb_hit;
  logic             page_fault;
  logic             evicted_valid;
  logic [EVP_W-1:0] evicted_page;
  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output evicted_valid, output evicted_page,
                  input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input page_fault, input evicted_valid, input evicted_page,
                output ready);
endinterface

interface tlbpt_cfg_if import tlbpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/tlbpt_tlb.sv]
// tlbpt_tlb: fully associative tlb with fifo pointer and recency order
// depends on tlbpt_pkg for tlb_ctl_t
module tlbpt_tlb import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PW = 8,
  parameter int FW = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlb_ctl_t                       ctl,
  input  logic [PW-1:0]                  page_i,
  input  logic [FW-1:0]                  frame_i,
  input  logic [PW-1:0]                  inval_page_i,
  input  logic [$clog2(TLB_ENTRIES)-1:0] slot_i,
  output logic                           hit_o,
  output logic [$clog2(TLB_ENTRIES)-1:0] hit_slot_o,
  output logic [FW-1:0]                  hit_frame_o,
  output logic [$clog2(TLB_ENTRIES)-1:0] ins_slot_o
);
  localparam int TW = $clog2(TLB_ENTRIES);

  logic [TLB_ENTRIES-1:0] vld_r;
  logic [PW-1:0]          pg_r  [TLB_ENTRIES];
  logic [FW-1:0]          fr_r  [TLB_ENTRIES];
  logic [TW-1:0]          rec_r [TLB_ENTRIES];
  logic [TW-1:0]          rec_nxt [TLB_ENTRIES];
  logic [TW-1:0]          fifo_r;

  always_comb begin
    hit_o = 1'b0;
    hit_slot_o = '0;
    hit_frame_o = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (vld_r[i] && pg_r[i] == page_i) begin
        hit_o = 1'b1;
        hit_slot_o = TW'(i);
        hit_frame_o = fr_r[i];
      end
    end
  end

  assign ins_slot_o = ctl.lru_policy ? rec_r[0] : fifo_r;

  // move the touched slot to the most recent end
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      seen = seen | (rec_r[i] == slot_i);
      if (i == TLB_ENTRIES - 1) rec_nxt[i] = slot_i;
      else if (seen) rec_nxt[i] = rec_r[i + 1];
      else rec_nxt[i] = rec_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fifo_r <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) rec_r[i] <= TW'(i);
    end else begin
      if (ctl.inval) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (vld_r[i] && pg_r[i] == inval_page_i) vld_r[i] <= 1'b0;
        end
      end
      if (ctl.insert) begin
        vld_r[ins_slot_o] <= 1'b1;
        if (!ctl.lru_policy) begin
          fifo_r <= (fifo_r == TW'(TLB_ENTRIES - 1)) ? '0 : fifo_r + 1'b1;
        end
      end
      if (ctl.touch) rec_r <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      pg_r[ins_slot_o] <= page_i;
      fr_r[ins_slot_o] <= frame_i;
    end
  end

endmodule

[design/tlbpt_lru_list.sv]
// tlbpt_lru_list: frame recency order as a doubly linked list in two memories
// depends on tlbpt_pkg for lru_ctl_t
module tlbpt_lru_list import tlbpt_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int FW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lru_ctl_t      ctl,
  input  logic [FW-1:0] frame_i,
  output logic [FW-1:0] head_o
);
  logic [FW-1:0] nxt_mem [FRAME_COUNT];
  logic [FW-1:0] prv_mem [FRAME_COUNT];
  logic [FW-1:0] nx_q, pv_q;
  logic [FW-1:0] head_r, tail_r;
  logic          moving_r;
  logic          nxt_we, prv_we;
  logic [FW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

  assign head_o = head_r;

  always_comb begin
    nxt_we = 1'b0; nxt_wa = frame_i; nxt_wd = frame_i + 1'b1;
    prv_we = 1'b0; prv_wa = frame_i; prv_wd = frame_i - 1'b1;
    if (ctl.clr) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (ctl.step_a) begin
      // unlink the frame unless it already is the most recent
      if (frame_i != tail_r) begin
        nxt_we = (frame_i != head_r);
        nxt_wa = pv_q;
        nxt_wd = nx_q;
        prv_we = 1'b1;
        prv_wa = nx_q;
        prv_wd = pv_q;
      end
    end else if (ctl.step_b) begin
      nxt_we = moving_r;
      nxt_wa = tail_r;
      nxt_wd = frame_i;
      prv_we = moving_r;
      prv_wa = frame_i;
      prv_wd = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (ctl.rd) nx_q <= nxt_mem[frame_i];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (ctl.rd) pv_q <= prv_mem[frame_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= FW'(FRAME_COUNT - 1);
      moving_r <= 1'b0;
    end else if (ctl.step_a) begin
      moving_r <= (frame_i != tail_r);
      if (frame_i != tail_r && frame_i == head_r) head_r <= nx_q;
    end else if (ctl.step_b && moving_r) begin
      tail_r <= frame_i;
    end
  end

endmodule

[design/tlb_page_table_translator_unit.sv]
// tlb_page_table_translator_unit: a tlb hit passes S_LOOK, S_TRD, S_TA and S_TB
// to S_DONE; a tlb miss adds S_PMAP and S_INS, a page fault also S_OWN and S_MAP.
// one item at a time: a new item is accepted only back in S_IDLE. after reset a
// clearing pass over max(PAGE_COUNT, FRAME_COUNT) entries (256 by default) runs
// with in_ready low.
// depends on tlbpt_pkg, tlbpt_if, tlbpt_tlb and tlbpt_lru_list
module tlb_page_table_translator_unit import tlbpt_pkg::*; #(
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  tlbpt_in_if.sink     in_ch,
  tlbpt_out_if.source  out_ch,
  tlbpt_cfg_if.sink    cfg_ch
);
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam int TW = $clog2(TLB_ENTRIES);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int CLR_N = (PAGE_COUNT > FRAME_COUNT) ? PAGE_COUNT : FRAME_COUNT;
  localparam int CW = $clog2(CLR_N);

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_LOOK = 11'b00000000100,
    S_PMAP = 11'b00000001000,
    S_OWN  = 11'b00000010000,
    S_MAP  = 11'b00000100000,
    S_INS  = 11'b00001000000,
    S_TRD  = 11'b00010000000,
    S_TA   = 11'b00100000000,
    S_TB   = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r;
  logic          frame_pol_r, tlb_pol_r;
  logic [PW-1:0] page_r;
  logic [OW-1:0] off_r;
  logic [FW-1:0] frame_r, victim_r, fifo_r, victim_c;
  logic [TW-1:0] slot_r;
  logic          hit_r, fault_r, evv_r;
  logic [PW-1:0] evp_r;
  logic [VA_W-1:0] va_pg;

  logic [FW:0]   pmap_mem [PAGE_COUNT];
  logic [FW:0]   pmap_q;
  logic          pmap_we;
  logic [PW-1:0] pmap_wa, pmap_ra;
  logic [FW:0]   pmap_wd;
  logic [PW:0]   own_mem [FRAME_COUNT];
  logic [PW:0]   own_q;
  logic          own_we;
  logic [FW-1:0] own_wa;
  logic [PW:0]   own_wd;

  tlb_ctl_t      tctl;
  lru_ctl_t      lctl;
  logic          t_hit;
  logic [TW-1:0] t_hit_slot, t_ins_slot;
  logic [FW-1:0] t_hit_frame, lru_head, lru_frame;

  logic            out_valid_r;
  logic [PA_W-1:0] out_pa_r;
  logic            out_hit_r, out_fault_r, out_evv_r;
  logic [EVP_W-1:0] out_evp_r;

  wire accept = in_ch.valid && in_ch.ready;
  wire clr_last = (clr_cnt_r == CW'(CLR_N - 1));

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign va_pg = in_ch.virtual_address / VA_W'(PAGE_BYTES);
  assign victim_c = frame_pol_r ? lru_head : fifo_r;

  // page table and frame owner memories
  always_comb begin
    pmap_we = 1'b0; pmap_wa = page_r; pmap_wd = {1'b1, victim_r};
    own_we = 1'b0; own_wa = victim_r; own_wd = {1'b1, page_r};
    pmap_ra = page_r;
    if (state_r == S_CLR) begin
      pmap_we = (32'(clr_cnt_r) < PAGE_COUNT);
      pmap_wa = PW'(clr_cnt_r);
      pmap_wd = '0;
      own_we = (32'(clr_cnt_r) < FRAME_COUNT);
      own_wa = FW'(clr_cnt_r);
      own_wd = '0;
    end else if (state_r == S_OWN) begin
      pmap_we = own_q[PW];
      pmap_wa = own_q[PW-1:0];
      pmap_wd = '0;
      own_we = 1'b1;
    end else if (state_r == S_MAP) begin
      pmap_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pmap_we) pmap_mem[pmap_wa] <= pmap_wd;
    pmap_q <= pmap_mem[pmap_ra];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_wa] <= own_wd;
    own_q <= own_mem[victim_c];
  end

  always_comb begin
    tctl.inval = (state_r == S_OWN) && own_q[PW];
    tctl.insert = (state_r == S_INS);
    tctl.touch = (state_r == S_TRD);
    tctl.lru_policy = tlb_pol_r;
    lctl.clr = (state_r == S_CLR) && (32'(clr_cnt_r) < FRAME_COUNT);
    lctl.rd = (state_r == S_TRD);
    lctl.step_a = (state_r == S_TA);
    lctl.step_b = (state_r == S_TB);
  end
  assign lru_frame = (state_r == S_CLR) ? FW'(clr_cnt_r) : frame_r;

  tlbpt_tlb #(.TLB_ENTRIES(TLB_ENTRIES), .PW(PW), .FW(FW)) u_tlb (
    .clk, .rst_n, .ctl(tctl), .page_i(page_r), .frame_i(frame_r),
    .inval_page_i(own_q[PW-1:0]), .slot_i(slot_r), .hit_o(t_hit),
    .hit_slot_o(t_hit_slot), .hit_frame_o(t_hit_frame), .ins_slot_o(t_ins_slot)
  );

  tlbpt_lru_list #(.FRAME_COUNT(FRAME_COUNT), .FW(FW)) u_lru (
    .clk, .rst_n, .ctl(lctl), .frame_i(lru_frame), .head_o(lru_head)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_last) state_nxt = S_IDLE;
      S_IDLE: if (accept) state_nxt = S_LOOK;
      S_LOOK: state_nxt = t_hit ? S_TRD : S_PMAP;
      S_PMAP: state_nxt = pmap_q[FW] ? S_INS : S_OWN;
      S_OWN:  state_nxt = S_MAP;
      S_MAP:  state_nxt = S_INS;
      S_INS:  state_nxt = S_TRD;
      S_TRD:  state_nxt = S_TA;
      S_TA:   state_nxt = S_TB;
      S_TB:   state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      frame_pol_r <= 1'b0;
      tlb_pol_r <= 1'b0;
      fifo_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_FRAME_POLICY: frame_pol_r <= cfg_ch.data[0];
          CFG_TLB_POLICY:   tlb_pol_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (state_r == S_PMAP && !pmap_q[FW] && !frame_pol_r) begin
        fifo_r <= (fifo_r == FW'(FRAME_COUNT - 1)) ? '0 : fifo_r + 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        page_r <= PW'(va_pg % VA_W'(PAGE_COUNT));
        off_r <= OW'(in_ch.virtual_address % VA_W'(PAGE_BYTES));
        hit_r <= 1'b0;
        fault_r <= 1'b0;
        evv_r <= 1'b0;
        evp_r <= '0;
      end
      S_LOOK: begin
        hit_r <= t_hit;
        frame_r <= t_hit_frame;
        slot_r <= t_hit_slot;
      end
      S_PMAP: begin
        frame_r <= pmap_q[FW-1:0];
        fault_r <= !pmap_q[FW];
        victim_r <= victim_c;
      end
      S_OWN: begin
        evv_r <= own_q[PW];
        evp_r <= own_q[PW] ? own_q[PW-1:0] : '0;
      end
      S_MAP: frame_r <= victim_r;
      S_INS: slot_r <= t_ins_slot;
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_pa_r <= PA_W'(32'(frame_r) * PAGE_BYTES + 32'(off_r));
          out_hit_r <= hit_r;
          out_fault_r <= fault_r;
          out_evv_r <= evv_r;
          out_evp_r <= EVP_W'(32'(evp_r));
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.physical_address = out_pa_r;
  assign out_ch.tlb_hit = out_hit_r;
  assign out_ch.page_fault = out_fault_r;
  assign out_ch.evicted_valid = out_evv_r;
  assign out_ch.evicted_page = out_evp_r;

  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.tlb_hit && out_ch.page_fault))
    else $error("tlb hit reported together with page fault");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.evicted_valid) |-> out_ch.page_fault)
    else $error("eviction without page fault");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item accepted while one is in work");

  a_no_evict_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP && evv_r) |-> evp_r != page_r)
    else $error("faulting page evicted itself");

endmodule

[verif/tlb_page_table_translator_unit_tb.sv]
// tlb_page_table_translator_unit_tb: checks address translation, tlb hits,
// page faults and evictions against a behavioral predictor of the same block
// depends on tlbpt_pkg, the tlbpt channel interfaces and the rtl top level
`timescale 1ns / 1ps

module tlb_page_table_translator_unit_tb;
  import tlbpt_pkg::*;

  localparam int NPAGE = 256;
  localparam int NFRAME = 128;
  localparam int NTLB = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [PA_W-1:0]  pa;
    logic             hit;
    logic             fault;
    logic             ev_valid;
    logic [EVP_W-1:0] ev_page;
  } xlat_t;

  typedef struct {
    logic [VA_W-1:0] va;
    bit              known;
    xlat_t           res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tlbpt_in_if  in_ch();
  tlbpt_out_if out_ch();
  tlbpt_cfg_if cfg_ch();

  tlb_page_table_translator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  bit              frame_lru, tlb_lru;
  bit              pm_valid[NPAGE];
  logic [6:0]      pm_frame[NPAGE];
  bit              fo_valid[NFRAME];
  logic [7:0]      fo_page[NFRAME];
  logic [6:0]      frame_order[NFRAME];
  logic [6:0]      frame_ptr;
  bit              te_valid[NTLB];
  logic [7:0]      te_page[NTLB];
  logic [6:0]      te_frame[NTLB];
  logic [3:0]      tlb_order[NTLB];
  logic [3:0]      tlb_ptr;

  xlat_t expected_xlats[$];
  int    errors = 0;
  int    idle_in_pct = 0, idle_out_pct = 0;
  bit    out_hold = 1'b0;
  bit    checked_known;
  xlat_t known_res;
  bit    known_pending[$];
  xlat_t known_vals[$];

  task automatic model_reset();
    frame_lru = 0; tlb_lru = 0; frame_ptr = '0; tlb_ptr = '0;
    for (int i = 0; i < NPAGE; i++) pm_valid[i] = 0;
    for (int i = 0; i < NFRAME; i++) begin
      fo_valid[i] = 0;
      frame_order[i] = 7'(i);
    end
    for (int i = 0; i < NTLB; i++) begin
      te_valid[i] = 0;
      tlb_order[i] = 4'(i);
    end
  endtask

  function automatic void touch_frame(input logic [6:0] f);
    int p;
    p = 0;
    while (frame_order[p] != f) p++;
    for (int i = p; i < NFRAME - 1; i++) frame_order[i] = frame_order[i+1];
    frame_order[NFRAME-1] = f;
  endfunction

  function automatic void touch_slot(input logic [3:0] s);
    int p;
    p = 0;
    while (tlb_order[p] != s) p++;
    for (int i = p; i < NTLB - 1; i++) tlb_order[i] = tlb_order[i+1];
    tlb_order[NTLB-1] = s;
  endfunction

  function automatic xlat_t translate(input logic [VA_W-1:0] va);
    xlat_t r;
    logic [7:0] page;
    logic [6:0] frame, victim;
    logic [3:0] slot;
    bit found;
    page = va[15:8];
    r = '0;
    found = 0;
    slot = '0;
    for (int i = 0; i < NTLB; i++)
      if (!found && te_valid[i] && te_page[i] == page) begin
        found = 1;
        slot = 4'(i);
      end
    if (found) begin
      r.hit = 1;
      frame = te_frame[slot];
    end else begin
      if (!pm_valid[page]) begin
        r.fault = 1;
        if (frame_lru) victim = frame_order[0];
        else begin
          victim = frame_ptr;
          frame_ptr = frame_ptr + 1'b1;
        end
        if (fo_valid[victim]) begin
          pm_valid[fo_page[victim]] = 0;
          for (int i = 0; i < NTLB; i++)
            if (te_valid[i] && te_page[i] == fo_page[victim]) te_valid[i] = 0;
          r.ev_valid = 1;
          r.ev_page = fo_page[victim];
        end
        fo_valid[victim] = 1;
        fo_page[victim] = page;
        pm_valid[page] = 1;
        pm_frame[page] = victim;
      end
      frame = pm_frame[page];
      if (tlb_lru) slot = tlb_order[0];
      else begin
        slot = tlb_ptr;
        tlb_ptr = tlb_ptr + 1'b1;
      end
      te_valid[slot] = 1;
      te_page[slot] = page;
      te_frame[slot] = frame;
    end
    touch_slot(slot);
    touch_frame(frame);
    r.pa = {frame, va[7:0]};
    return r;
  endfunction

  // valid stays high from one item to the next unless the sender idles
  task automatic send_va(input logic [VA_W-1:0] va, input bit known = 1'b0,
                         input xlat_t kr = '0);
    if (idle_in_pct != 0 && $urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_in_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.virtual_address <= va;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_xlats.push_back(translate(va));
    known_pending.push_back(known);
    known_vals.push_back(kr);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_FRAME_POLICY) frame_lru = data;
    else if (idx == CFG_TLB_POLICY) tlb_lru = data;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_xlats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_xlats.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          xlat_t e;
          e = expected_xlats.pop_front();
          checked_known = known_pending.pop_front();
          known_res = known_vals.pop_front();
          if (checked_known && known_res != e) begin
            $error("directed row disagrees with predictor: %h vs %h", known_res, e);
            errors++;
          end
          if (out_ch.physical_address !== e.pa) begin
            $error("physical_address exp %h got %h", e.pa, out_ch.physical_address);
            errors++;
          end
          if (out_ch.tlb_hit !== e.hit) begin
            $error("tlb_hit exp %0d got %0d", e.hit, out_ch.tlb_hit);
            errors++;
          end
          if (out_ch.page_fault !== e.fault) begin
            $error("page_fault exp %0d got %0d", e.fault, out_ch.page_fault);
            errors++;
          end
          if (out_ch.evicted_valid !== e.ev_valid) begin
            $error("evicted_valid exp %0d got %0d", e.ev_valid, out_ch.evicted_valid);
            errors++;
          end
          if (out_ch.evicted_page !== e.ev_page) begin
            $error("evicted_page exp %h got %h", e.ev_page, out_ch.evicted_page);
            errors++;
          end
        end
      end
      out_ch.ready <= !out_hold &&
                      !(idle_out_pct != 0 && $urandom_range(99) < idle_out_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (rst_n);
    repeat (2000) @(posedge clk);
    out_hold = 1'b1;
    repeat (300) @(posedge clk);
    out_hold = 1'b0;
  end

  initial begin
    #20ms;
    $display("tlb_page_table_translator_unit_tb: FAIL");
    $finish;
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(input logic [VA_W-1:0] va, input bit known,
                                   input logic [PA_W-1:0] pa, input bit h,
                                   input bit f, input bit ev, input logic [7:0] evp);
    dir_row_t d;
    d.va = va;
    d.known = known;
    d.res = '{pa, h, f, ev, evp};
    return d;
  endfunction

  // random address: mostly a small working set so hits and evictions happen
  function automatic logic [VA_W-1:0] rand_va(input int span);
    logic [7:0] pg;
    if ($urandom_range(9) < 2) pg = 8'($urandom);
    else pg = 8'($urandom_range(span - 1));
    return {pg, 8'($urandom)};
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.virtual_address = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: first access faults into frame 0, repeat hits the tlb
    dir_rows.push_back(row(16'h0000, 1, 15'h0000, 0, 1, 0, 8'h00));
    dir_rows.push_back(row(16'h00FF, 1, 15'h00FF, 1, 0, 0, 8'h00));
    dir_rows.push_back(row(16'hFFFF, 1, 15'h01FF, 0, 1, 0, 8'h00));
    dir_rows.push_back(row(16'hFF00, 1, 15'h0100, 1, 0, 0, 8'h00));
    dir_rows.push_back(row(16'hAA55, 1, 15'h0255, 0, 1, 0, 8'h00));
    dir_rows.push_back(row(16'h55AA, 1, 15'h03AA, 0, 1, 0, 8'h00));
    for (int i = 0; i < 18; i++) dir_rows.push_back(row(16'(i * 16'h0101 + 16'h0400),
                                                       0, '0, 0, 0, 0, '0));
    foreach (dir_rows[i]) send_va(dir_rows[i].va, dir_rows[i].known, dir_rows[i].res);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_FRAME_POLICY, ph[0]);
      write_reg(CFG_TLB_POLICY, ph[1]);
      if (ph == 5) write_reg(CFG_IDX_SPARE, 1'b1);  // unused index, ignored
      case (ph % 3)
        0: begin idle_in_pct = 13; idle_out_pct = 48; end
        1: begin idle_in_pct = 48; idle_out_pct = 13; end
        default: begin idle_in_pct = 0; idle_out_pct = 0; end
      endcase
      for (int n = 0; n < 200; n++)
        send_va(rand_va(ph < 3 ? 150 : 24));
      drain();
    end

    if (errors == 0) $display("tlb_page_table_translator_unit_tb: PASS");
    else $display("tlb_page_table_translator_unit_tb: FAIL");
    $finish;
  end

endmodule

[tlb_page_table_translator_unit.f]
design/tlbpt_pkg.sv
design/tlbpt_if.sv
design/tlbpt_tlb.sv
design/tlbpt_lru_list.sv
design/tlb_page_table_translator_unit.sv
verif/tlb_page_table_translator_unit_tb.sv
